FILE: sv/ard_se_kernel_with_gradient_macros.svh
// Assertion shorthands used by the top-level RTL file.
`ifndef ARD_SE_KERNEL_WITH_GRADIENT_MACROS_SVH
`define ARD_SE_KERNEL_WITH_GRADIENT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ARD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define ARD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ard_se_pkg.sv
`default_nettype none

package ard_se_pkg;

    localparam int DIMENSIONS = 4;

    localparam int COORD_W    = 16;
    localparam int SCALE_W    = 16;
    localparam int VALUE_W    = 32;
    localparam int KIND_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int NUM_RES   = DIMENSIONS + 2;
    localparam int RES_IDX_W = $clog2(NUM_RES);
    localparam int RES_CNT_W = $clog2(NUM_RES + 1);

    localparam int D2_W    = 2 * COORD_W;
    localparam int L2_W    = 2 * SCALE_W;
    localparam int L3_W    = 3 * SCALE_W;
    localparam int EXPO_W  = 39;
    localparam int EXQ_W   = 40;
    localparam int EX_W    = 33;
    localparam int SE_W    = 64;
    localparam int GNUM_W  = 72;
    localparam int RECIP_W = 37;

    // exponent cap of 64.0 in Q.32
    localparam logic [EXPO_W-1:0] EXPO_CAP = {1'b1, {(EXPO_W-1){1'b0}}};
    localparam logic [31:0]       LN2_Q32  = 32'd2977044472;

    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = CFG_IDX_W'(DIMENSIONS);
    localparam logic [CFG_IDX_W-1:0] REG_GRAD_EN   = CFG_IDX_W'(DIMENSIONS + 1);

    localparam logic [KIND_W-1:0] KIND_COV = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_AMP = KIND_W'(DIMENSIONS + 1);

    typedef struct packed {
        logic load;
        logic grad_go;
    } lane_ctrl_t;

    typedef struct packed {
        logic               e_done;
        logic               g_done;
        logic [EXPO_W-1:0]  e;
        logic [VALUE_W-1:0] g;
    } lane_stat_t;

    // floor(2^36 / k) for the Horner divisors
    function automatic logic [RECIP_W-1:0] recip_k(input logic [3:0] k);
        logic [RECIP_W-1:0] r;
        case (k)
            4'd1:    r = 37'd68719476736;
            4'd2:    r = 37'd34359738368;
            4'd3:    r = 37'd22906492245;
            4'd4:    r = 37'd17179869184;
            4'd5:    r = 37'd13743895347;
            4'd6:    r = 37'd11453246122;
            4'd7:    r = 37'd9817068105;
            4'd8:    r = 37'd8589934592;
            4'd9:    r = 37'd7635497415;
            4'd10:   r = 37'd6871947673;
            4'd11:   r = 37'd6247225157;
            4'd12:   r = 37'd5726623061;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/ard_se_kernel_with_gradient.sv
// ARD squared-exponential kernel with gradients. Each item is a pair of
// four-dimensional points (signed Q8.8); the block returns the covariance
// s^2*exp(-sum d_i^2/(2 l_i^2)) as unsigned Q16.16, and when gradient_enable
// is set it follows with the four length-scale derivatives and the amplitude
// derivative, value_kind telling them apart and last marking the final one.
// Four lanes work on the four dimensions at once and a merge stage sums their
// exponent terms. The lanes' dividers are radix-4. The exp unit does 7
// range-reduction steps and then 12 Horner steps, each through a multiply,
// a reciprocal and a fix state on one shared multiplier chain; with
// gradients on, the gradient products and dividers follow (16 divider
// steps). A one-item input buffer takes the next pair while the current
// one computes, and a result bank drains one result per cycle while
// out_stall is low, as the next pair starts.
// Configuration is written through cfg_wen/cfg_index/cfg_data while idle;
// allow two cycles after a length-scale write before sending an item.
`default_nettype none

`include "ard_se_kernel_with_gradient_macros.svh"

module ard_se_kernel_with_gradient
    import ard_se_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wen,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COORD_W-1:0] coord_x_0,
    input  logic signed [COORD_W-1:0] coord_x_1,
    input  logic signed [COORD_W-1:0] coord_x_2,
    input  logic signed [COORD_W-1:0] coord_x_3,
    input  logic signed [COORD_W-1:0] coord_y_0,
    input  logic signed [COORD_W-1:0] coord_y_1,
    input  logic signed [COORD_W-1:0] coord_y_2,
    input  logic signed [COORD_W-1:0] coord_y_3,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [KIND_W-1:0]         value_kind,
    output logic [VALUE_W-1:0]        value,
    output logic                      last
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EDIV  = 4'd1;
    localparam logic [3:0] S_SUM   = 4'd2;
    localparam logic [3:0] S_EXPGO = 4'd3;
    localparam logic [3:0] S_EXP   = 4'd4;
    localparam logic [3:0] S_POST  = 4'd5;
    localparam logic [3:0] S_GGO   = 4'd6;
    localparam logic [3:0] S_GDIV  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    localparam int ESUM_W = EXPO_W + $clog2(DIMENSIONS);

    // configuration
    logic [SCALE_W-1:0] scale_reg [DIMENSIONS];
    logic [SCALE_W-1:0] amplitude_reg;
    logic               grad_en_reg;
    logic [L2_W-1:0]    s2_reg;

    // input buffer
    logic signed [COORD_W-1:0] cx [DIMENSIONS];
    logic signed [COORD_W-1:0] cy [DIMENSIONS];
    logic signed [COORD_W-1:0] x_buf_reg [DIMENSIONS];
    logic signed [COORD_W-1:0] y_buf_reg [DIMENSIONS];
    logic                      buf_valid_reg;
    logic                      in_take;

    // core
    logic [3:0]         state_reg;
    lane_ctrl_t         lane_ctrl;
    lane_stat_t         stat [DIMENSIONS];
    logic               e_done_all;
    logic               g_done_all;
    logic [ESUM_W-1:0]  esum_full;
    logic [EXPO_W-1:0]  esum_reg;
    logic               ex_done;
    logic [EX_W-1:0]    ex;
    logic [SE_W-1:0]    se_reg;
    logic [64:0]        se_full;
    logic [48:0]        amp_full;
    logic [VALUE_W-1:0] amp_res_reg;

    // result bank and output register
    logic [VALUE_W-1:0]   bank_val_reg [NUM_RES];
    logic [RES_CNT_W-1:0] bank_idx_reg;
    logic [RES_CNT_W-1:0] bank_n_reg;
    logic                 bank_free;
    logic                 emit;
    logic                 out_valid_reg;
    logic [KIND_W-1:0]    out_kind_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic                 out_last_reg;

    assign cx[0] = coord_x_0;
    assign cx[1] = coord_x_1;
    assign cx[2] = coord_x_2;
    assign cx[3] = coord_x_3;
    assign cy[0] = coord_y_0;
    assign cy[1] = coord_y_1;
    assign cy[2] = coord_y_2;
    assign cy[3] = coord_y_3;

    // ---------------------------------------------------------------
    // Configuration registers; scale and s^2 products settle behind them
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIMENSIONS; i++)
                scale_reg[i] <= SCALE_W'(256);
            amplitude_reg <= SCALE_W'(256);
            grad_en_reg   <= 1'b0;
        end
        else if (cfg_wen)
        begin
            for (int i = 0; i < DIMENSIONS; i++)
            begin
                if (cfg_index == CFG_IDX_W'(i))
                    scale_reg[i] <= cfg_data;
            end
            if (cfg_index == REG_AMPLITUDE)
                amplitude_reg <= cfg_data;
            if (cfg_index == REG_GRAD_EN)
                grad_en_reg <= cfg_data[0];
        end
    end

    always_ff @(posedge clk)
    begin
        s2_reg <= L2_W'(amplitude_reg) * L2_W'(amplitude_reg);
    end

    // ---------------------------------------------------------------
    // Input buffer: hold one pair while the core works on the previous one
    // ---------------------------------------------------------------
    assign in_stall = buf_valid_reg;
    assign in_take  = (state_reg == S_IDLE) && buf_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            buf_valid_reg <= 1'b0;
        else if (in_valid && !buf_valid_reg)
            buf_valid_reg <= 1'b1;
        else if (in_take)
            buf_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !buf_valid_reg)
        begin
            for (int i = 0; i < DIMENSIONS; i++)
            begin
                x_buf_reg[i] <= cx[i];
                y_buf_reg[i] <= cy[i];
            end
        end
    end

    // ---------------------------------------------------------------
    // Lanes, one per dimension
    // ---------------------------------------------------------------
    assign lane_ctrl.load    = in_take;
    assign lane_ctrl.grad_go = (state_reg == S_GGO);

    for (genvar g = 0; g < DIMENSIONS; g++)
    begin : g_lane
        ard_se_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .x     (x_buf_reg[g]),
            .y     (y_buf_reg[g]),
            .scale (scale_reg[g]),
            .se    (se_reg),
            .ctrl  (lane_ctrl),
            .stat  (stat[g])
        );
    end

    // merge: all lanes run in lockstep; sum exponent terms, clamp at 64.0
    always_comb
    begin
        e_done_all = 1'b1;
        g_done_all = 1'b1;
        esum_full  = '0;
        for (int i = 0; i < DIMENSIONS; i++)
        begin
            e_done_all = e_done_all & stat[i].e_done;
            g_done_all = g_done_all & stat[i].g_done;
            esum_full  = esum_full + ESUM_W'(stat[i].e);
        end
    end

    ard_se_exp u_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_EXPGO),
        .e_sum (esum_reg),
        .done  (ex_done),
        .ex    (ex)
    );

    assign se_full  = 65'(s2_reg) * 65'(ex);
    assign amp_full = 49'(amplitude_reg) * 49'(ex);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SUM)
            esum_reg <= (esum_full > ESUM_W'(EXPO_CAP)) ? EXPO_CAP
                                                        : esum_full[EXPO_W-1:0];
        if (state_reg == S_POST)
        begin
            se_reg      <= se_full[SE_W-1:0];
            amp_res_reg <= VALUE_W'(amp_full >> 23);
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign bank_free = (bank_idx_reg == bank_n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:  if (buf_valid_reg) state_reg <= S_EDIV;
                S_EDIV:  if (e_done_all) state_reg <= S_SUM;
                S_SUM:   state_reg <= S_EXPGO;
                S_EXPGO: state_reg <= S_EXP;
                S_EXP:   if (ex_done) state_reg <= S_POST;
                S_POST:  state_reg <= grad_en_reg ? S_GGO : S_DONE;
                S_GGO:   state_reg <= S_GDIV;
                S_GDIV:  if (g_done_all) state_reg <= S_DONE;
                S_DONE:  if (bank_free) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Result bank: the result kind equals its slot
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && bank_free)
        begin
            bank_val_reg[0] <= se_reg[SE_W-1:32];
            for (int i = 0; i < DIMENSIONS; i++)
                bank_val_reg[i+1] <= stat[i].g;
            bank_val_reg[NUM_RES-1] <= amp_res_reg;
        end
    end

    assign emit = !bank_free && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_idx_reg  <= '0;
            bank_n_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_DONE) && bank_free)
            begin
                bank_idx_reg <= '0;
                bank_n_reg   <= grad_en_reg ? RES_CNT_W'(NUM_RES) : RES_CNT_W'(1);
            end
            else if (emit)
            begin
                bank_idx_reg <= bank_idx_reg + RES_CNT_W'(1);
            end

            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            value_reg    <= bank_val_reg[bank_idx_reg[RES_IDX_W-1:0]];
            out_kind_reg <= KIND_W'(bank_idx_reg);
            out_last_reg <= (bank_idx_reg + RES_CNT_W'(1)) == bank_n_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign value_kind = out_kind_reg;
    assign last       = out_last_reg;

    `ARD_ASSERT_NEXT(a_buf_consumed, in_take, !buf_valid_reg, "buffered item not consumed")
    `ARD_ASSERT_NOW(a_bank_order, 1'b1, bank_idx_reg <= bank_n_reg, "bank index past count")
    `ARD_ASSERT_NOW(a_last_kind, out_valid_reg && out_last_reg, out_kind_reg == KIND_COV || out_kind_reg == KIND_AMP, "last on wrong kind")
    `ARD_ASSERT_NOW(a_lanes_lockstep, stat[0].e_done, e_done_all, "lanes out of step")

endmodule

`default_nettype wire

FILE: sv/ard_se_div.sv
`default_nettype none

// Restoring divider, two quotient bits per cycle, fixed latency.
module ard_se_div
    import ard_se_pkg::*;
#(
    parameter int NUM_W    = 63,
    parameter int DEN_W    = 32,
    parameter int QUO_BITS = 40
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_W-1:0]    num,
    input  logic [DEN_W-1:0]    den,
    output logic                done,
    output logic [QUO_BITS-1:0] quo,
    output logic                sat
);

    localparam int STEPS = QUO_BITS / 2;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int CMP_W = NUM_W + DEN_W + QUO_BITS;

    logic [CNT_W-1:0]    cnt_reg;
    logic                done_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [DEN_W-1:0]    rem_next;
    logic [QUO_BITS-1:0] low_reg;
    logic [QUO_BITS-1:0] low_next;
    logic [QUO_BITS-1:0] quo_reg;
    logic [QUO_BITS-1:0] quo_next;
    logic                sat_reg;
    logic                sat_now;
    logic [DEN_W:0]      trial;

    // quotient would not fit in QUO_BITS
    assign sat_now = CMP_W'(num) >= (CMP_W'(den) << QUO_BITS);

    always_comb
    begin
        rem_next = rem_reg;
        low_next = low_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int s = 0; s < 2; s++)
        begin
            trial    = {rem_next, low_next[QUO_BITS-1]};
            low_next = {low_next[QUO_BITS-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                trial    = trial - {1'b0, den_reg};
                quo_next = {quo_next[QUO_BITS-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_next[QUO_BITS-2:0], 1'b0};
            end
            rem_next = trial[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start)
                cnt_reg <= CNT_W'(STEPS);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= DEN_W'(num >> QUO_BITS);
            low_reg <= num[QUO_BITS-1:0];
            quo_reg <= '0;
            sat_reg <= sat_now;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign sat  = sat_reg;

endmodule

`default_nettype wire

FILE: sv/ard_se_lane.sv
`default_nettype none

// One dimension: squared distance, exponent term, length-scale derivative.
module ard_se_lane
    import ard_se_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [COORD_W-1:0] x,
    input  logic signed [COORD_W-1:0] y,
    input  logic [SCALE_W-1:0]        scale,
    input  logic [SE_W-1:0]           se,
    input  lane_ctrl_t                ctrl,
    output lane_stat_t                stat
);

    logic [SCALE_W-1:0]      l_eff;
    logic [L2_W-1:0]         l2_reg;
    logic [L3_W-1:0]         l3_reg;
    logic signed [COORD_W:0] diff;
    logic signed [COORD_W:0] neg;
    logic [COORD_W-1:0]      mag;
    logic [D2_W-1:0]         d2_reg;
    logic                    e_go_reg;
    logic [63:0]             pp_lo_reg;
    logic [63:0]             pp_hi_reg;
    logic [95:0]             gprod;
    logic [GNUM_W-1:0]       gnum_reg;
    logic                    g_sum_go_reg;
    logic                    g_go_reg;
    logic                    e_done;
    logic [EXQ_W-1:0]        e_quo;
    logic                    e_sat;
    logic                    g_done;
    logic [VALUE_W-1:0]      g_quo;
    logic                    g_sat;

    // zero scale acts as the smallest step
    assign l_eff = (scale == '0) ? SCALE_W'(1) : scale;
    assign diff  = {x[COORD_W-1], x} - {y[COORD_W-1], y};
    assign neg   = -diff;
    assign mag   = diff[COORD_W] ? neg[COORD_W-1:0] : diff[COORD_W-1:0];
    assign gprod = {pp_hi_reg, 32'b0} + {32'b0, pp_lo_reg};

    always_ff @(posedge clk)
    begin
        l2_reg <= L2_W'(l_eff) * L2_W'(l_eff);
        l3_reg <= L3_W'(l2_reg) * L3_W'(l_eff);
        if (ctrl.load)
            d2_reg <= D2_W'(mag) * D2_W'(mag);
        if (ctrl.grad_go)
        begin
            pp_lo_reg <= 64'(se[31:0]) * 64'(d2_reg);
            pp_hi_reg <= 64'(se[63:32]) * 64'(d2_reg);
        end
        if (g_sum_go_reg)
            gnum_reg <= gprod[95:24];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_go_reg     <= 1'b0;
            g_sum_go_reg <= 1'b0;
            g_go_reg     <= 1'b0;
        end
        else
        begin
            e_go_reg     <= ctrl.load;
            g_sum_go_reg <= ctrl.grad_go;
            g_go_reg     <= g_sum_go_reg;
        end
    end

    // d^2 / (2 l^2) in Q.32 equals d^2 * 2^31 / l^2
    ard_se_div #(
        .NUM_W    (D2_W + 31),
        .DEN_W    (L2_W),
        .QUO_BITS (EXQ_W)
    ) u_div_e (
        .clk   (clk),
        .rst_n (rst_n),
        .start (e_go_reg),
        .num   ({d2_reg, 31'b0}),
        .den   (l2_reg),
        .done  (e_done),
        .quo   (e_quo),
        .sat   (e_sat)
    );

    ard_se_div #(
        .NUM_W    (GNUM_W),
        .DEN_W    (L3_W),
        .QUO_BITS (VALUE_W)
    ) u_div_g (
        .clk   (clk),
        .rst_n (rst_n),
        .start (g_go_reg),
        .num   (gnum_reg),
        .den   (l3_reg),
        .done  (g_done),
        .quo   (g_quo),
        .sat   (g_sat)
    );

    assign stat.e_done = e_done;
    assign stat.g_done = g_done;
    assign stat.e      = (e_sat || (e_quo > EXQ_W'(EXPO_CAP))) ? EXPO_CAP
                                                              : e_quo[EXPO_W-1:0];
    assign stat.g      = g_sat ? '1 : g_quo;

endmodule

`default_nettype wire

FILE: sv/ard_se_exp.sv
`default_nettype none

// exp(-E) in Q1.32: range reduction by ln2, then a 12-term Horner series.
module ard_se_exp
    import ard_se_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [EXPO_W-1:0] e_sum,
    output logic              done,
    output logic [EX_W-1:0]   ex
);

    localparam logic [2:0] EX_IDLE = 3'd0;
    localparam logic [2:0] EX_QDIV = 3'd1;
    localparam logic [2:0] EX_MUL  = 3'd2;
    localparam logic [2:0] EX_REC  = 3'd3;
    localparam logic [2:0] EX_FIX  = 3'd4;

    localparam logic [EX_W-1:0] ONE_Q32 = {1'b1, 32'b0};

    logic [2:0]              state_reg;
    logic [2:0]              bit_reg;
    logic [EXPO_W-1:0]       rem_reg;
    logic [6:0]              qexp_reg;
    logic [31:0]             r_reg;
    logic [EX_W-1:0]         t_reg;
    logic [3:0]              k_reg;
    logic [64:0]             prod_reg;
    logic [31:0]             p_reg;
    logic [68:0]             m_reg;
    logic [EX_W-1:0]         ex_reg;
    logic                    done_reg;
    logic [EXPO_W-1:0]       ln_sh;
    logic                    q_bit;
    logic [EXPO_W-1:0]       rem_next;
    logic [31:0]             q0;
    logic [35:0]             qk;
    logic [31:0]             r0;
    logic [31:0]             qq;
    logic [EX_W-1:0]         t_new;

    assign ln_sh    = EXPO_W'(LN2_Q32) << bit_reg;
    assign q_bit    = rem_reg >= ln_sh;
    assign rem_next = q_bit ? rem_reg - ln_sh : rem_reg;

    // floor(p / k) from the reciprocal, off by at most one
    assign q0    = m_reg[67:36];
    assign qk    = 36'(q0) * 36'(k_reg);
    assign r0    = p_reg - qk[31:0];
    assign qq    = (r0 >= 32'(k_reg)) ? q0 + 32'd1 : q0;
    assign t_new = ONE_Q32 - EX_W'(qq);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EX_IDLE;
            done_reg  <= 1'b0;
            bit_reg   <= '0;
            rem_reg   <= '0;
            qexp_reg  <= '0;
            r_reg     <= '0;
            t_reg     <= '0;
            k_reg     <= '0;
            prod_reg  <= '0;
            p_reg     <= '0;
            m_reg     <= '0;
            ex_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                EX_IDLE:
                begin
                    if (start)
                    begin
                        rem_reg   <= e_sum;
                        bit_reg   <= 3'd6;
                        qexp_reg  <= '0;
                        state_reg <= EX_QDIV;
                    end
                end
                EX_QDIV:
                begin
                    rem_reg  <= rem_next;
                    qexp_reg <= {qexp_reg[5:0], q_bit};
                    bit_reg  <= bit_reg - 3'd1;
                    if (bit_reg == 3'd0)
                    begin
                        r_reg     <= rem_next[31:0];
                        t_reg     <= ONE_Q32;
                        k_reg     <= 4'd12;
                        state_reg <= EX_MUL;
                    end
                end
                EX_MUL:
                begin
                    prod_reg  <= 65'(r_reg) * 65'(t_reg);
                    state_reg <= EX_REC;
                end
                EX_REC:
                begin
                    p_reg     <= prod_reg[63:32];
                    m_reg     <= 69'(prod_reg[63:32]) * 69'(recip_k(k_reg));
                    state_reg <= EX_FIX;
                end
                EX_FIX:
                begin
                    t_reg <= t_new;
                    if (k_reg == 4'd1)
                    begin
                        ex_reg    <= (qexp_reg >= 7'd63) ? '0 : (t_new >> qexp_reg);
                        done_reg  <= 1'b1;
                        state_reg <= EX_IDLE;
                    end
                    else
                    begin
                        k_reg     <= k_reg - 4'd1;
                        state_reg <= EX_MUL;
                    end
                end
                default:
                begin
                    state_reg <= EX_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign ex   = ex_reg;

endmodule

`default_nettype wire

FILE: verif/ard_se_kernel_with_gradient_tb.sv
`default_nettype none

module ard_se_kernel_with_gradient_tb;
    import ard_se_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT   = 1500000;
    // wait after the last result, long enough to cover one item with gradients on
    localparam int  SETTLE_CYCLES = 120;
    localparam int  RANDOM_ITEMS  = 400;
    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
    // indexes past the last register, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_GRAD_EN + CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = REG_GRAD_EN + CFG_IDX_W'(2);

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] val;
        logic               fin;
    } kernel_result_t;

    typedef logic signed [COORD_W-1:0] point_t [DIMENSIONS];

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wen;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [COORD_W-1:0] coord_x_0, coord_x_1, coord_x_2, coord_x_3;
    logic signed [COORD_W-1:0] coord_y_0, coord_y_1, coord_y_2, coord_y_3;
    logic                      out_valid;
    logic                      out_stall;
    logic [KIND_W-1:0]         value_kind;
    logic [VALUE_W-1:0]        value;
    logic                      last;

    ard_se_kernel_with_gradient u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .coord_x_0  (coord_x_0),
        .coord_x_1  (coord_x_1),
        .coord_x_2  (coord_x_2),
        .coord_x_3  (coord_x_3),
        .coord_y_0  (coord_y_0),
        .coord_y_1  (coord_y_1),
        .coord_y_2  (coord_y_2),
        .coord_y_3  (coord_y_3),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value_kind (value_kind),
        .value      (value),
        .last       (last)
    );

    // Shadow copy of the register file, updated on each write we issue to one of its registers
    logic [SCALE_W-1:0] shadow_scale [DIMENSIONS];
    logic [SCALE_W-1:0] shadow_amp;
    logic               shadow_grad;

    kernel_result_t pending_results [$];

    int  mismatches;
    int  unexpected;
    int  items_sent;
    int  results_seen;
    int  grad_items;
    int  cycles;
    bit  quiet_links;   // set to run a stretch with no idling on either side
    int  stall_hold;

    // start low so that no rising edge falls on time zero
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Predictor: covariance and derivatives of one point pair
    // ------------------------------------------------------------------

    // exp(-e) for e in Q.32, result in Q1.32
    function automatic logic [63:0] exp_neg_fixed(input logic [63:0] e);
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] t;
        q = e / 64'(LN2_Q32);
        r = e - q * 64'(LN2_Q32);
        t = 64'd1 << 32;
        for (int k = 12; k >= 1; k--)
            t = (64'd1 << 32) - (((r * t) >> 32) / 64'(unsigned'(k)));
        if (q >= 64'd63)
            return 64'd0;
        return t >> q;
    endfunction

    function automatic logic [63:0] eff_scale(input logic [SCALE_W-1:0] l);
        // a zero length scale acts as the smallest nonzero one
        return (l == '0) ? 64'd1 : 64'(l);
    endfunction

    task automatic predict_kernel(input point_t px, input point_t py);
        logic [63:0]   d2 [DIMENSIONS];
        logic [63:0]   e_sum;
        logic [63:0]   e;
        logic [63:0]   l;
        logic [63:0]   ex;
        logic [63:0]   s;
        logic [63:0]   se;
        logic [127:0]  wide;
        logic signed [COORD_W:0] d;
        logic [COORD_W:0] m;
        kernel_result_t res;
        e_sum = '0;
        for (int i = 0; i < DIMENSIONS; i++)
        begin
            d = {px[i][COORD_W-1], px[i]} - {py[i][COORD_W-1], py[i]};
            m = d[COORD_W] ? -d : d;
            d2[i] = 64'(m) * 64'(m);
            l = eff_scale(shadow_scale[i]);
            e = (d2[i] << 32) / (64'd2 * l * l);
            if (e > (64'd64 << 32))
                e = 64'd64 << 32;
            e_sum += e;
            if (e_sum > (64'd64 << 32))
                e_sum = 64'd64 << 32;
        end
        ex = exp_neg_fixed(e_sum);
        s  = 64'(shadow_amp);
        se = s * s * ex;

        res.kind = KIND_COV;
        res.val  = se[63:32];
        res.fin  = !shadow_grad;
        pending_results.push_back(res);
        if (!shadow_grad)
            return;

        for (int i = 0; i < DIMENSIONS; i++)
        begin
            l = eff_scale(shadow_scale[i]);
            wide = (128'(se) * 128'(d2[i])) >> 24;
            wide = wide / 128'(l * l * l);
            res.kind = KIND_W'(1 + i);
            res.val  = (wide > 128'(VALUE_MAX)) ? VALUE_MAX : wide[VALUE_W-1:0];
            res.fin  = 1'b0;
            pending_results.push_back(res);
        end
        wide = (128'(s) * 128'(ex)) >> 23;
        res.kind = KIND_AMP;
        res.val  = wide[VALUE_W-1:0];
        res.fin  = 1'b1;
        pending_results.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare each accepted item with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        kernel_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                unexpected++;
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing pending: kind %0d value %h last %0b",
                             $realtime, value_kind, value, last);
            end
            else
            begin
                want = pending_results.pop_front();
                if (value_kind !== want.kind || value !== want.val || last !== want.fin)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch: expected kind %0d value %h last %0b, got kind %0d value %h last %0b",
                                 $realtime, want.kind, want.val, want.fin,
                                 value_kind, value, last);
                end
            end
        end
    end

    // Receiver back-pressure: mostly no stall or a short one, now and then a long one
    always @(posedge clk)
    begin
        int pick;
        if (quiet_links)
        begin
            out_stall  <= 1'b0;
            stall_hold <= 0;
        end
        else if (stall_hold > 0)
            stall_hold <= stall_hold - 1;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                out_stall  <= 1'b0;
                stall_hold <= $urandom_range(0, 15);
            end
            else if (pick < 95)
            begin
                out_stall  <= 1'b1;
                stall_hold <= $urandom_range(0, 3);
            end
            else
            begin
                out_stall  <= 1'b1;
                stall_hold <= $urandom_range(10, 40);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycles, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic int sender_gap();
        int pick;
        if (quiet_links)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return 0;
        if (pick < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 100);
    endfunction

    // Present one point pair, hold it until accepted, then predict and sometimes idle
    task automatic send_pair(input point_t px, input point_t py);
        int gap;
        in_valid  <= 1'b1;
        coord_x_0 <= px[0];
        coord_x_1 <= px[1];
        coord_x_2 <= px[2];
        coord_x_3 <= px[3];
        coord_y_0 <= py[0];
        coord_y_1 <= py[1];
        coord_y_2 <= py[2];
        coord_y_3 <= py[3];
        do
            @(posedge clk);
        while (in_stall);
        predict_kernel(px, py);
        items_sent++;
        if (shadow_grad)
            grad_items++;
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every predicted item has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write; call only while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wen <= 1'b0;
        if (idx < CFG_IDX_W'(DIMENSIONS))
            shadow_scale[idx] = data;
        else if (idx == REG_AMPLITUDE)
            shadow_amp = data;
        else if (idx == REG_GRAD_EN)
            shadow_grad = data[0];
        // length scales settle through the squared and cubed scale registers
        repeat (2) @(posedge clk);
    endtask

    task automatic write_all(input logic [SCALE_W-1:0] l0, input logic [SCALE_W-1:0] l1,
                             input logic [SCALE_W-1:0] l2, input logic [SCALE_W-1:0] l3,
                             input logic [SCALE_W-1:0] amp, input logic grad);
        write_reg(CFG_IDX_W'(0), l0);
        write_reg(CFG_IDX_W'(1), l1);
        write_reg(CFG_IDX_W'(2), l2);
        write_reg(CFG_IDX_W'(3), l3);
        write_reg(REG_AMPLITUDE, amp);
        write_reg(REG_GRAD_EN, {{(CFG_DATA_W-1){1'b0}}, grad});
    endtask

    task automatic send_uniform(input logic signed [COORD_W-1:0] xv,
                                input logic signed [COORD_W-1:0] yv);
        point_t px;
        point_t py;
        for (int i = 0; i < DIMENSIONS; i++)
        begin
            px[i] = xv;
            py[i] = yv;
        end
        send_pair(px, py);
    endtask

    function automatic logic [SCALE_W-1:0] random_scale();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return '0;
        if (pick < 10)
            return '1;
        if (pick < 15)
            return SCALE_W'(1);
        if (pick < 70)
            return SCALE_W'($urandom_range(128, 2048));
        return SCALE_W'($urandom);
    endfunction

    // Mostly nearby points so the exponential is not flushed to zero
    task automatic send_random_pair();
        point_t px;
        point_t py;
        int     base;
        int     span;
        int     pick;
        pick = $urandom_range(0, 99);
        span = (pick < 40) ? 64 : (pick < 75) ? 1024 : 0;
        for (int i = 0; i < DIMENSIONS; i++)
        begin
            px[i] = COORD_W'($urandom);
            if (span == 0)
                py[i] = COORD_W'($urandom);
            else
            begin
                base = int'(px[i]) + $urandom_range(0, 2 * span) - span;
                if (base > 32767)
                    base = 32767;
                if (base < -32768)
                    base = -32768;
                py[i] = COORD_W'(base);
            end
        end
        send_pair(px, py);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: unit length scales, unit amplitude, covariance only
    task automatic test_reset_defaults();
        send_uniform(16'sd0, 16'sd0);
        send_uniform(16'sd256, -16'sd256);
        send_uniform(16'sd100, 16'sd37);
        drain_results();
    endtask

    // Field and register extremes, zero length scale, ignored writes
    task automatic test_directed_corners();
        write_all(16'd256, 16'd256, 16'd256, 16'd256, 16'd256, 1'b1);
        send_uniform(16'sd0, 16'sd0);
        send_uniform(16'sh7FFF, -16'sh8000);
        send_uniform(-16'sh8000, 16'sh7FFF);
        send_uniform(16'sd128, 16'sd0);
        send_uniform(-16'sd1, 16'sd0);
        drain_results();

        // zero scales behave as the smallest one; smallest difference
        write_all(16'd0, 16'd1, 16'd0, 16'd1, 16'hFFFF, 1'b1);
        send_uniform(16'sd1, 16'sd0);
        send_uniform(16'sd0, 16'sd0);
        send_uniform(16'sd3, -16'sd2);
        drain_results();

        // largest scales, with the largest coordinate distance among the pairs
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_uniform(16'sh7FFF, -16'sh8000);
        send_uniform(16'sd4096, -16'sd4096);
        send_uniform(16'sd0, 16'sd0);
        drain_results();

        // zero amplitude
        write_reg(REG_AMPLITUDE, 16'd0);
        send_uniform(16'sd512, 16'sd0);
        drain_results();

        // writes to spare indexes and upper data bits of the enable must not count
        write_reg(REG_GRAD_EN, 16'hFFFE);
        write_reg(REG_SPARE_LO, 16'h0000);
        write_reg(REG_SPARE_HI, 16'h1234);
        write_reg(REG_AMPLITUDE, 16'd300);
        send_uniform(16'sd200, -16'sd50);
        send_uniform(16'sh7FFF, 16'sh7FFF);
        drain_results();
        write_reg(REG_GRAD_EN, 16'hFFFF);
        send_uniform(16'sd200, -16'sd50);
        drain_results();
    endtask

    // Random pairs over a series of random settings
    task automatic test_random_settings();
        int phase_len;
        int done;
        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            write_all(random_scale(), random_scale(), random_scale(), random_scale(),
                      ($urandom_range(0, 9) == 0) ? SCALE_W'($urandom)
                                                  : SCALE_W'($urandom_range(0, 1024)),
                      1'($urandom_range(0, 3) != 0));
            quiet_links = ($urandom_range(0, 4) == 0);
            phase_len = $urandom_range(10, 40);
            for (int n = 0; n < phase_len && done < RANDOM_ITEMS; n++)
            begin
                send_random_pair();
                done++;
                // hold off now and then until everything is back
                if ($urandom_range(0, 49) == 0)
                    drain_results();
            end
            drain_results();
            quiet_links = 1'b0;
        end
    endtask

    initial
    begin
        mismatches   = 0;
        unexpected   = 0;
        items_sent   = 0;
        results_seen = 0;
        grad_items   = 0;
        cycles       = 0;
        quiet_links  = 1'b0;
        stall_hold   = 0;
        shadow_scale = '{default: 16'd256};
        shadow_amp   = 16'd256;
        shadow_grad  = 1'b0;
        rst_n      <= 1'b0;
        cfg_wen    <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        out_stall  <= 1'b0;
        coord_x_0  <= '0;
        coord_x_1  <= '0;
        coord_x_2  <= '0;
        coord_x_3  <= '0;
        coord_y_0  <= '0;
        coord_y_1  <= '0;
        coord_y_2  <= '0;
        coord_y_3  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        test_reset_defaults();
        test_directed_corners();
        test_random_settings();
        drain_results();

        $display("sent %0d point pairs (%0d with derivatives), checked %0d results",
                 items_sent, grad_items, results_seen);
        $display("settings covered zero, unit and full-scale length scales and amplitudes");
        if (mismatches == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches, %0d unexpected, %0d pending",
                     mismatches, unexpected, pending_results.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+sv
sv/ard_se_pkg.sv
sv/ard_se_div.sv
sv/ard_se_lane.sv
sv/ard_se_exp.sv
sv/ard_se_kernel_with_gradient.sv
verif/ard_se_kernel_with_gradient_tb.sv
